// ===== rtl/cgb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgb_pkg
// Shared types, constants and helpers of the cell grid height lookup unit.
// ----------------------------------------------------------------------------
package cgb_pkg;

  // Store sizes.
  localparam int MAX_CELLS   = 4096;
  localparam int MAX_SAMPLES = 65536;
  localparam int MAX_SIDE    = 16;
  localparam int CELL_AW     = $clog2(MAX_CELLS);
  localparam int SMP_AW      = $clog2(MAX_SAMPLES);
  localparam int BASE_W      = SMP_AW + 1;
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes.
  localparam logic [2:0] REG_CELLS_ACROSS = 3'd0;
  localparam logic [2:0] REG_CELLS_DOWN   = 3'd1;
  localparam logic [2:0] REG_SIDE         = 3'd2;
  localparam logic [2:0] REG_INV_SIZE     = 3'd3;
  localparam logic [2:0] REG_ORIGIN_X     = 3'd4;
  localparam logic [2:0] REG_ORIGIN_Y     = 3'd5;

  // Heights and fractions.
  localparam logic [23:0] SENTINEL   = 24'hC00000;
  localparam logic [23:0] FRAC_CLAMP = 24'd16760439;

  // Result status codes.
  localparam logic [1:0] ST_FOUND      = 2'd0;
  localparam logic [1:0] ST_NOT_LOADED = 2'd1;
  localparam logic [1:0] ST_OUTSIDE    = 2'd2;

  typedef enum logic [1:0] {
    OP_CELL   = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  typedef struct packed {
    logic [12:0]        cells_across;
    logic [12:0]        cells_down;
    logic [4:0]         samples_per_side;
    logic [23:0]        inverse_cell_size;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
  } cfg_t;

  typedef struct packed {
    logic              patch_on;
    logic [BASE_W-1:0] base;
    logic [23:0]       sec;
    logic [23:0]       def;
  } cell_word_t;

  localparam int CELL_W = $bits(cell_word_t);

  // One queued job for the back end.
  typedef struct packed {
    op_t                op;
    logic [CELL_AW-1:0] cell_addr;
    cell_word_t         cell_data;
    logic [SMP_AW-1:0]  smp_addr;
    logic [23:0]        smp;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic               loaded;
    logic               ovf;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MULLO, S_MULHI, S_SUM, S_IDX, S_FRAC, S_CELLRD, S_CELL,
    S_RD, S_MT, S_AT, S_MB, S_AB, S_MH, S_AH, S_OUT
  } bstate_t;

  // Side length actually used: zero acts as one, large values clip.
  function automatic logic [4:0] side_eff(input logic [4:0] s);
    logic [4:0] r;
    if (s == 5'd0) r = 5'd1;
    else if (s > 5'(MAX_SIDE)) r = 5'(MAX_SIDE);
    else r = s;
    return r;
  endfunction

endpackage

// ===== rtl/cgb_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgb_if
// Valid/ready channels for input items and lookup results.
// ----------------------------------------------------------------------------
interface cgb_item_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [23:0] cell_default_height;
  logic signed [23:0] cell_secondary_height;
  logic               cell_has_patch;
  logic signed [23:0] sample_height;
  logic signed [31:0] query_x;
  logic signed [31:0] query_y;

  modport source (output valid, opcode, cell_default_height, cell_secondary_height,
                  cell_has_patch, sample_height, query_x, query_y, input ready);
  modport sink (input valid, opcode, cell_default_height, cell_secondary_height,
                cell_has_patch, sample_height, query_x, query_y, output ready);
endinterface

interface cgb_result_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] height;
  logic signed [23:0] secondary;
  logic [1:0]         status;
  logic               overflow;

  modport source (output valid, height, secondary, status, overflow, input ready);
  modport sink (input valid, height, secondary, status, overflow, output ready);
endinterface

// ===== rtl/cgb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgb_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module cgb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== rtl/cgb_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgb_front
// Accepts items, allocates cell and sample slots, and queues jobs.
// ----------------------------------------------------------------------------
module cgb_front (
  input  logic            clk,
  input  logic            rst,
  input  cgb_pkg::cfg_t   cfg,
  cgb_item_if.sink        items,
  input  logic            full,
  output logic            push,
  output cgb_pkg::entry_t push_entry
);
  import cgb_pkg::*;

  logic [12:0]       cells_loaded, cells_loaded_next;
  logic [BASE_W-1:0] samples_loaded, samples_loaded_next;
  logic [BASE_W-1:0] next_base, next_base_next;
  logic              overflow_seen, overflow_seen_next;
  logic              accept;
  logic [25:0]       total;
  logic [4:0]        side;
  logic [9:0]        need;
  logic              loaded;

  assign items.ready = !full;
  assign accept      = items.valid && items.ready;
  assign total       = 26'(cfg.cells_across) * 26'(cfg.cells_down);
  assign side        = side_eff(cfg.samples_per_side);
  assign need        = 10'(side) * 10'(side);
  assign loaded      = (26'(cells_loaded) == total) && (samples_loaded == next_base);

  // Allocation and job building.
  always_comb begin
    cells_loaded_next   = cells_loaded;
    samples_loaded_next = samples_loaded;
    next_base_next      = next_base;
    overflow_seen_next  = overflow_seen;
    push                = 1'b0;
    push_entry          = '0;
    push_entry.dx       = 33'(items.query_x) - 33'(cfg.origin_x);
    push_entry.dy       = 33'(items.query_y) - 33'(cfg.origin_y);
    push_entry.loaded   = loaded;
    push_entry.ovf      = overflow_seen;
    push_entry.smp      = items.sample_height;
    push_entry.smp_addr = samples_loaded[SMP_AW-1:0];
    push_entry.cell_addr = cells_loaded[CELL_AW-1:0];
    push_entry.cell_data.def = items.cell_default_height;
    push_entry.cell_data.sec = items.cell_secondary_height;
    if (accept) begin
      case (items.opcode)
        OP_CELL: begin
          if (26'(cells_loaded) >= total) begin
            push = 1'b0;
          end else if (cells_loaded >= 13'(MAX_CELLS)) begin
            overflow_seen_next = 1'b1;
          end else begin
            push            = 1'b1;
            push_entry.op   = OP_CELL;
            cells_loaded_next = cells_loaded + 13'd1;
            if (items.cell_has_patch) begin
              if (18'(next_base) + 18'(need) > 18'(MAX_SAMPLES)) begin
                overflow_seen_next = 1'b1;
              end else begin
                push_entry.cell_data.patch_on = 1'b1;
                push_entry.cell_data.base     = next_base;
                next_base_next                = next_base + BASE_W'(need);
              end
            end
          end
        end
        OP_SAMPLE: begin
          if (samples_loaded < next_base && samples_loaded < BASE_W'(MAX_SAMPLES)) begin
            push                = 1'b1;
            push_entry.op       = OP_SAMPLE;
            samples_loaded_next = samples_loaded + BASE_W'(1);
          end
        end
        OP_QUERY: begin
          push          = 1'b1;
          push_entry.op = OP_QUERY;
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cells_loaded   <= '0;
      samples_loaded <= '0;
      next_base      <= '0;
      overflow_seen  <= 1'b0;
    end else begin
      cells_loaded   <= cells_loaded_next;
      samples_loaded <= samples_loaded_next;
      next_base      <= next_base_next;
      overflow_seen  <= overflow_seen_next;
    end
  end
endmodule

// ===== rtl/cgb_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgb_queue
// Short job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module cgb_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  cgb_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output cgb_pkg::entry_t head
);
  import cgb_pkg::*;

  localparam int QA_W = $clog2(QUEUE_DEPTH);

  entry_t          slots [QUEUE_DEPTH];
  logic [QA_W-1:0] wr_ptr;
  logic [QA_W-1:0] rd_ptr;
  logic [QA_W:0]   count;

  assign full       = (count == (QA_W + 1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  // Storage is written without reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QA_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QA_W'(1);
      count <= count + (QA_W + 1)'(push) - (QA_W + 1)'(pop);
    end
  end
endmodule

// ===== rtl/cgb_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgb_back
// Executes queued jobs: store writes, and queries through a multi-cycle
// sequence of cell lookup, four sample reads and bilinear blending.
// ----------------------------------------------------------------------------
module cgb_back (
  input  logic            clk,
  input  logic            rst,
  input  cgb_pkg::cfg_t   cfg,
  input  logic            head_valid,
  input  cgb_pkg::entry_t head,
  output logic            pop,
  cgb_result_if.source    results
);
  import cgb_pkg::*;

  bstate_t state, state_next;

  // Memory ports.
  logic                cell_we, cell_re;
  logic [CELL_W-1:0]   cell_rdata;
  cell_word_t          cell_q;
  logic                smp_we, smp_re;
  logic [SMP_AW-1:0]   smp_raddr;
  logic [23:0]         smp_rdata;

  // Query datapath registers.
  logic signed [32:0]  dx, dy;
  logic [40:0]         plo_x, plo_y;
  logic signed [40:0]  phi_x, phi_y;
  logic signed [57:0]  bx, by;
  logic                in_grid;
  logic [CELL_AW-1:0]  idx;
  logic [3:0]          ix, iy;
  logic [24:0]         wx, wy;
  logic [17:0]         saddr [4];
  logic signed [23:0]  smp [4];
  logic [2:0]          rd_k;
  logic signed [53:0]  prod;
  logic signed [26:0]  top, bot;
  logic signed [23:0]  res_h, res_sec;
  logic [1:0]          res_st;
  logic                res_ovf;
  logic                out_load;

  // Combinational helpers.
  logic [4:0]          side;
  logic [3:0]          m;
  logic [32:0]         cx, cy;
  logic                in_grid_c;
  logic [25:0]         idx_c;
  logic [23:0]         fx, fy, cfx, cfy;
  logic [27:0]         pmx, pmy, fmx, fmy;
  logic [3:0]          ix_c, iy_c, ix1, iy1;
  logic [27:0]         wx_c, wy_c;
  logic [17:0]         row0, row1;
  logic signed [53:0]  prod_rnd;
  logic signed [29:0]  rnd;
  logic signed [29:0]  h_sum;

  assign cell_q = cell_word_t'(cell_rdata);
  assign side   = side_eff(cfg.samples_per_side);
  assign m      = 4'(side - 5'd1);

  // Cell index and range checks from the scaled coordinates.
  assign cx        = bx[56:24];
  assign cy        = by[56:24];
  assign in_grid_c = !bx[57] && !by[57] && (cx[32:13] == '0) && (cy[32:13] == '0) &&
                     (cx[12:0] < cfg.cells_across) && (cy[12:0] < cfg.cells_down);
  assign idx_c     = 26'(cy[12:0]) * 26'(cfg.cells_across) + 26'(cx[12:0]);

  // Patch fraction: sample index from the clamped fraction, weight from the raw one.
  assign fx   = bx[23:0];
  assign fy   = by[23:0];
  assign cfx  = (fx > FRAC_CLAMP) ? FRAC_CLAMP : fx;
  assign cfy  = (fy > FRAC_CLAMP) ? FRAC_CLAMP : fy;
  assign pmx  = 28'(cfx) * 28'(m);
  assign pmy  = 28'(cfy) * 28'(m);
  assign fmx  = 28'(fx) * 28'(m);
  assign fmy  = 28'(fy) * 28'(m);
  assign ix_c = pmx[27:24];
  assign iy_c = pmy[27:24];
  assign wx_c = fmx - {ix_c, 24'd0};
  assign wy_c = fmy - {iy_c, 24'd0};

  // Neighbor indexes clamp at the last sample of a row or column.
  assign ix1  = (ix >= m) ? m : ix + 4'd1;
  assign iy1  = (iy >= m) ? m : iy + 4'd1;
  assign row0 = 18'(cell_q.base) + 18'(9'(iy) * 9'(side));
  assign row1 = 18'(cell_q.base) + 18'(9'(iy1) * 9'(side));

  // Round to nearest by adding one half and shifting down.
  assign prod_rnd = prod + 54'sd8388608;
  assign rnd      = prod_rnd[53:24];
  assign h_sum    = 30'(top) + rnd;

  cgb_ram #(.WIDTH(CELL_W), .DEPTH(MAX_CELLS)) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (head.cell_addr),
    .wdata (head.cell_data),
    .re    (cell_re),
    .raddr (idx),
    .rdata (cell_rdata)
  );

  cgb_ram #(.WIDTH(24), .DEPTH(MAX_SAMPLES)) u_smp_ram (
    .clk   (clk),
    .we    (smp_we),
    .waddr (head.smp_addr),
    .wdata (head.smp),
    .re    (smp_re),
    .raddr (smp_raddr),
    .rdata (smp_rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (head_valid && head.op == OP_QUERY) begin
          state_next = head.loaded ? S_MULLO : S_OUT;
        end
      end
      S_MULLO:  state_next = S_MULHI;
      S_MULHI:  state_next = S_SUM;
      S_SUM:    state_next = S_IDX;
      S_IDX:    state_next = S_FRAC;
      S_FRAC:   state_next = in_grid ? S_CELLRD : S_OUT;
      S_CELLRD: state_next = S_CELL;
      S_CELL:   state_next = cell_q.patch_on ? S_RD : S_OUT;
      S_RD:     state_next = (rd_k == 3'd4) ? S_MT : S_RD;
      S_MT:     state_next = S_AT;
      S_AT:     state_next = S_MB;
      S_MB:     state_next = S_AB;
      S_AB:     state_next = S_MH;
      S_MH:     state_next = S_AH;
      S_AH:     state_next = S_OUT;
      S_OUT:    state_next = out_load ? S_IDLE : S_OUT;
      default:  state_next = S_IDLE;
    endcase
  end

  // Memory and queue controls.
  always_comb begin
    pop       = (state == S_IDLE) && head_valid;
    cell_we   = pop && (head.op == OP_CELL);
    smp_we    = pop && (head.op == OP_SAMPLE);
    cell_re   = (state == S_CELLRD);
    smp_re    = (state == S_RD) && (rd_k < 3'd4);
    smp_raddr = saddr[rd_k[1:0]][SMP_AW-1:0];
    out_load  = (state == S_OUT) && (!results.valid || results.ready);
  end

  // Query datapath.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        dx      <= head.dx;
        dy      <= head.dy;
        res_ovf <= head.ovf;
        res_st  <= ST_NOT_LOADED;
        res_h   <= SENTINEL;
        res_sec <= SENTINEL;
      end
      S_MULLO: begin
        plo_x <= 41'(dx[16:0]) * 41'(cfg.inverse_cell_size);
        plo_y <= 41'(dy[16:0]) * 41'(cfg.inverse_cell_size);
      end
      S_MULHI: begin
        phi_x <= 41'($signed(dx[32:17])) * 41'($signed({1'b0, cfg.inverse_cell_size}));
        phi_y <= 41'($signed(dy[32:17])) * 41'($signed({1'b0, cfg.inverse_cell_size}));
      end
      S_SUM: begin
        bx <= {phi_x, 17'd0} + $signed({17'd0, plo_x});
        by <= {phi_y, 17'd0} + $signed({17'd0, plo_y});
      end
      S_IDX: begin
        in_grid <= in_grid_c;
        idx     <= idx_c[CELL_AW-1:0];
        res_st  <= ST_OUTSIDE;
      end
      S_FRAC: begin
        ix <= ix_c;
        iy <= iy_c;
        wx <= wx_c[24:0];
        wy <= wy_c[24:0];
      end
      S_CELL: begin
        res_st   <= ST_FOUND;
        res_h    <= cell_q.def;
        res_sec  <= cell_q.sec;
        saddr[0] <= row0 + 18'(ix);
        saddr[1] <= row0 + 18'(ix1);
        saddr[2] <= row1 + 18'(ix);
        saddr[3] <= row1 + 18'(ix1);
      end
      S_MT: prod <= 54'(25'(smp[1]) - 25'(smp[0])) * 54'($signed({1'b0, wx}));
      S_AT: top  <= 27'(smp[0]) + 27'(rnd);
      S_MB: prod <= 54'(25'(smp[3]) - 25'(smp[2])) * 54'($signed({1'b0, wx}));
      S_AB: bot  <= 27'(smp[2]) + 27'(rnd);
      S_MH: prod <= 54'(28'(bot) - 28'(top)) * 54'($signed({1'b0, wy}));
      S_AH: begin
        if (h_sum > 30'sd8388607) res_h <= 24'sd8388607;
        else if (h_sum < -30'sd8388608) res_h <= -24'sd8388608;
        else res_h <= h_sum[23:0];
      end
      default: begin
      end
    endcase
  end

  // Sample reads: one address per cycle, data captured in the following cycle.
  always_ff @(posedge clk) begin
    if (state == S_RD) begin
      rd_k <= rd_k + 3'd1;
      if (rd_k != 3'd0) begin
        smp[rd_k[1:0] - 2'd1] <= (saddr[rd_k[1:0] - 2'd1][17:16] != 2'd0) ? 24'sd0 :
                                 smp_rdata;
      end
    end else begin
      rd_k <= 3'd0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (out_load) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      results.height    <= res_h;
      results.secondary <= res_sec;
      results.status    <= res_st;
      results.overflow  <= res_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule

// ===== rtl/cell_grid_bilinear_height_lookup_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_grid_bilinear_height_lookup_unit
// Cell grid height map: loads cells and detail samples, answers height
// queries with bilinear blending inside detail patches.
// ----------------------------------------------------------------------------
//  channel  | direction | transfers
//  ---------+-----------+------------------------------------------------
//  items    | in        | cell load, sample load or query, one per item
//  results  | out       | one result per query
//  cfg_*    | in        | register write, no handshake
//
//  Loads are written as the back end pops them; the front end accepts one item
//  per cycle while the four-entry job queue has room.
//  A query holds the back end, which pops no new job, until its result is
//  loaded. Its path runs through the split position multiply, the four
//  reads of the single sample RAM port and the three blend multiplies, and
//  ends early before loading completes, outside the grid or without a patch.
//  Reset is synchronous and needs no clearing pass; a stalled result holds
//  the back end in its last step while the front keeps filling the queue.
// ----------------------------------------------------------------------------
module cell_grid_bilinear_height_lookup_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  cgb_item_if.sink    items,
  cgb_result_if.source results
);
  import cgb_pkg::*;

  cfg_t   cfg;
  logic   push, full, pop, head_valid;
  entry_t push_entry, head;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cells_across      <= '0;
      cfg.cells_down        <= '0;
      cfg.samples_per_side  <= 5'd2;
      cfg.inverse_cell_size <= 24'd65536;
      cfg.origin_x          <= '0;
      cfg.origin_y          <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CELLS_ACROSS: cfg.cells_across      <= cfg_data[12:0];
        REG_CELLS_DOWN:   cfg.cells_down        <= cfg_data[12:0];
        REG_SIDE:         cfg.samples_per_side  <= cfg_data[4:0];
        REG_INV_SIZE:     cfg.inverse_cell_size <= cfg_data[23:0];
        REG_ORIGIN_X:     cfg.origin_x          <= cfg_data;
        REG_ORIGIN_Y:     cfg.origin_y          <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  cgb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .items      (items),
    .full       (full),
    .push       (push),
    .push_entry (push_entry)
  );

  cgb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  cgb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .results    (results)
  );
endmodule

// ===== rtl/cgb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgb_checker
// Port-level checks of the height lookup unit, bound to the top level.
// ----------------------------------------------------------------------------
module cgb_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [23:0] res_height,
  input logic [23:0] res_secondary,
  input logic [1:0]  res_status,
  input logic        res_overflow
);
  import cgb_pkg::*;

  // A pending result stays offered until it is transferred.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped before transfer");

  // Nothing is offered right after a reset cycle.
  assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result offered right after reset");

  // A miss reports the sentinel for both heights.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_status == ST_NOT_LOADED || res_status == ST_OUTSIDE) |->
      res_height == SENTINEL && res_secondary == SENTINEL)
    else $error("miss without sentinel heights");

  // Status never takes the unused code.
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_status != 2'd3)
    else $error("unused status code");

  // The overflow flag is sticky across successive results.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && res_overflow ##1 res_valid |-> res_overflow)
    else $error("overflow flag cleared");
endmodule

bind cell_grid_bilinear_height_lookup_unit cgb_checker u_cgb_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (results.valid),
  .res_ready     (results.ready),
  .res_height    (results.height),
  .res_secondary (results.secondary),
  .res_status    (results.status),
  .res_overflow  (results.overflow)
);
